>>> hdl/ean8_barcode_encoder_macros.svh
// assertion macros shared by the encoder modules
`ifndef EAN8_BARCODE_ENCODER_MACROS_SVH
`define EAN8_BARCODE_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every edge out of reset
`define EAN8_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define EAN8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define EAN8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define EAN8_ASSERT_ALWAYS(lbl, cond, msg)
`define EAN8_ASSERT_IMP(lbl, ante, cons, msg)
`define EAN8_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/ean8_pkg.sv
`default_nettype none

package ean8_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int SUM_W      = 8;
  localparam int SEG_W      = 4;
  localparam int PAT_W      = 7;
  localparam int LEN_W      = 3;
  localparam int QUIET_W    = 8;
  localparam int KIND_W     = 2;

  localparam logic [QUIET_W-1:0] QUIET_RESET = 8'd7;

  // segment kinds
  localparam logic [KIND_W-1:0] KIND_QUIET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GUARD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd2;

  // segment positions within one code
  localparam logic [SEG_W-1:0] SEG_QUIET_L = 4'd0;
  localparam logic [SEG_W-1:0] SEG_START   = 4'd1;
  localparam logic [SEG_W-1:0] SEG_LEFT0   = 4'd2;
  localparam logic [SEG_W-1:0] SEG_LEFT3   = 4'd5;
  localparam logic [SEG_W-1:0] SEG_CENTRE  = 4'd6;
  localparam logic [SEG_W-1:0] SEG_RIGHT0  = 4'd7;
  localparam logic [SEG_W-1:0] SEG_RIGHT3  = 4'd10;
  localparam logic [SEG_W-1:0] SEG_END     = 4'd11;
  localparam logic [SEG_W-1:0] SEG_QUIET_R = 4'd12;

  localparam logic [PAT_W-1:0] PAT_SIDE_GUARD   = 7'h05;
  localparam logic [PAT_W-1:0] PAT_CENTRE_GUARD = 7'h0A;
  localparam logic [LEN_W-1:0] LEN_SIDE_GUARD   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_CENTRE_GUARD = 3'd5;
  localparam logic [LEN_W-1:0] LEN_DIGIT        = 3'd7;

  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // one classified code as it waits in the queue
  typedef struct packed {
    digits_t digits;
    logic    cerr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [PAT_W-1:0] lcode(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] p;
    case (d)
      4'd0:    p = 7'h0D;
      4'd1:    p = 7'h19;
      4'd2:    p = 7'h13;
      4'd3:    p = 7'h3D;
      4'd4:    p = 7'h23;
      4'd5:    p = 7'h31;
      4'd6:    p = 7'h2F;
      4'd7:    p = 7'h3B;
      4'd8:    p = 7'h37;
      4'd9:    p = 7'h0B;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [PAT_W-1:0] rcode(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] p;
    case (d)
      4'd0:    p = 7'h72;
      4'd1:    p = 7'h66;
      4'd2:    p = 7'h6C;
      4'd3:    p = 7'h42;
      4'd4:    p = 7'h5C;
      4'd5:    p = 7'h4E;
      4'd6:    p = 7'h50;
      4'd7:    p = 7'h44;
      4'd8:    p = 7'h48;
      4'd9:    p = 7'h74;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ean8_front.sv
`default_nettype none

module ean8_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ean8_pkg::digits_t    in_digits,
  input  ean8_pkg::fifo_stat_t fifo_stat,
  output logic                 push,
  output ean8_pkg::item_t      push_item
);
  import ean8_pkg::*;

  logic                 vld_r, vld_nxt;
  digits_t              dig_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [15:0]          recip;
  logic [4:0]           quot;
  logic [SUM_W-1:0]     rem_full;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   chk;
  logic                 accept;

  assign in_stall = vld_r && fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = vld_r && !fifo_stat.full;

  // weight 3 on even positions, 1 on odd ones; raw 4-bit values go in
  always_comb begin
    sum_nxt = 8'd3 * ({4'd0, in_digits[0]} + {4'd0, in_digits[2]}
                    + {4'd0, in_digits[4]} + {4'd0, in_digits[6]})
            + {4'd0, in_digits[1]} + {4'd0, in_digits[3]} + {4'd0, in_digits[5]};
  end

  // sum mod 10 by reciprocal: floor(x*205/2048) equals x/10 for x below 1029
  always_comb begin
    recip    = {8'd0, sum_r} * 16'd205;
    quot     = recip[15:11];
    rem_full = sum_r - ({3'd0, quot} * 8'd10);
    rem      = rem_full[DIGIT_W-1:0];
    chk      = (rem == '0) ? '0 : (4'd10 - rem);
  end

  assign push_item.digits = dig_r;
  assign push_item.cerr   = (chk != dig_r[NUM_DIGITS-1]);

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dig_r <= in_digits;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ean8_fifo.sv
`default_nettype none

`include "ean8_barcode_encoder_macros.svh"

module ean8_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  ean8_pkg::item_t      push_item,
  input  wire                  pop,
  output ean8_pkg::item_t      head,
  output ean8_pkg::fifo_stat_t stat
);
  import ean8_pkg::*;

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `EAN8_ASSERT_ALWAYS(a_no_overflow, !(push && stat.full), "push into full queue")
  `EAN8_ASSERT_ALWAYS(a_no_underflow, !(pop && stat.empty), "pop from empty queue")
  `EAN8_ASSERT_ALWAYS(a_cnt_range, cnt_r != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

>>> hdl/ean8_back.sv
`default_nettype none

`include "ean8_barcode_encoder_macros.svh"

module ean8_back (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire  [ean8_pkg::QUIET_W-1:0]              quiet_width,
  input  ean8_pkg::item_t                           head,
  input  ean8_pkg::fifo_stat_t                      fifo_stat,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire                                       out_stall,
  output logic [ean8_pkg::KIND_W-1:0]               out_seg_kind,
  output logic [ean8_pkg::PAT_W-1:0]                out_pattern,
  output logic [ean8_pkg::LEN_W-1:0]                out_pattern_len,
  output logic [ean8_pkg::QUIET_W-1:0]              out_quiet_len,
  output logic                                      out_check_error,
  output logic                                      out_bad_digit,
  output logic                                      out_last
);
  import ean8_pkg::*;

  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic               ov_r, ov_nxt;
  logic               load;
  logic [2:0]         dsel;
  logic [DIGIT_W-1:0] dig;

  logic [KIND_W-1:0]  kind;
  logic [PAT_W-1:0]   pat;
  logic [LEN_W-1:0]   len;
  logic [QUIET_W-1:0] qlen;
  logic               bad;
  logic               lst;

  logic [KIND_W-1:0]  kind_r;
  logic [PAT_W-1:0]   pat_r;
  logic [LEN_W-1:0]   len_r;
  logic [QUIET_W-1:0] qlen_r;
  logic               cerr_r;
  logic               bad_r;
  logic               lst_r;

  assign load = !fifo_stat.empty && (!ov_r || !out_stall);
  assign pop  = load && (seg_r == SEG_QUIET_R);

  // left digits sit at segments 2..5, right digits at 7..10
  always_comb begin
    if (seg_r < SEG_CENTRE) begin
      dsel = 3'(seg_r - SEG_LEFT0);
    end else begin
      dsel = 3'(seg_r - (SEG_RIGHT0 - 4'd4));
    end
    dig = head.digits[dsel];
  end

  always_comb begin
    kind = KIND_GUARD;
    pat  = '0;
    len  = '0;
    qlen = '0;
    bad  = 1'b0;
    lst  = 1'b0;
    if (seg_r == SEG_QUIET_L || seg_r == SEG_QUIET_R) begin
      kind = KIND_QUIET;
      qlen = quiet_width;
      lst  = (seg_r == SEG_QUIET_R);
    end else if (seg_r == SEG_START || seg_r == SEG_END) begin
      pat = PAT_SIDE_GUARD;
      len = LEN_SIDE_GUARD;
    end else if (seg_r == SEG_CENTRE) begin
      pat = PAT_CENTRE_GUARD;
      len = LEN_CENTRE_GUARD;
    end else begin
      kind = KIND_DIGIT;
      if (dig > MAX_DIGIT) begin
        bad = 1'b1;
      end else begin
        len = LEN_DIGIT;
        pat = (seg_r inside {[SEG_LEFT0:SEG_LEFT3]}) ? lcode(dig) : rcode(dig);
      end
    end
  end

  always_comb begin
    seg_nxt = seg_r;
    if (load) begin
      seg_nxt = (seg_r == SEG_QUIET_R) ? SEG_QUIET_L : seg_r + 4'd1;
    end
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_QUIET_L;
      ov_r  <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind;
      pat_r  <= pat;
      len_r  <= len;
      qlen_r <= qlen;
      cerr_r <= head.cerr;
      bad_r  <= bad;
      lst_r  <= lst;
    end
  end

  assign out_valid       = ov_r;
  assign out_seg_kind    = kind_r;
  assign out_pattern     = pat_r;
  assign out_pattern_len = len_r;
  assign out_quiet_len   = qlen_r;
  assign out_check_error = cerr_r;
  assign out_bad_digit   = bad_r;
  assign out_last        = lst_r;

  `EAN8_ASSERT_ALWAYS(a_seg_range, seg_r <= SEG_QUIET_R, "segment counter out of range")
  `EAN8_ASSERT_IMP(a_last_quiet, out_valid && out_last, out_seg_kind == KIND_QUIET,
                   "last flag on a non-quiet segment")
  `EAN8_ASSERT_IMP(a_bad_empty, out_valid && out_bad_digit,
                   out_seg_kind == KIND_DIGIT && out_pattern_len == '0,
                   "bad digit segment carries a pattern")
  `EAN8_ASSERT_NEXT(a_wrap, pop, seg_r == SEG_QUIET_L && out_valid && out_last,
                    "queue pop without trailing quiet segment")

endmodule

`default_nettype wire

>>> hdl/ean8_barcode_encoder.sv
// channel | ports                          | moves on
// --------+--------------------------------+------------------------------
// cfg     | cfg_wr_en, cfg_wr_data         | write enable high, no wait
// in      | in_valid, in_stall, in_digit_* | valid high and stall low
// out     | out_valid, out_stall, out_*    | valid high and stall low
//
// each code gives 13 output beats, one per cycle while out_stall is low; the first
// beat of a code is valid once the code has passed the check-sum stage, the queue
// and the output register.
// reset (rst_n low, synchronous) empties the pipeline and sets quiet_width to 7.
// a stalled output holds its beat; the two-entry queue lets the input keep
// taking codes while the output side is stalled.
`default_nettype none

module ean8_barcode_encoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [3:0]  in_digit_0,
  input  wire  [3:0]  in_digit_1,
  input  wire  [3:0]  in_digit_2,
  input  wire  [3:0]  in_digit_3,
  input  wire  [3:0]  in_digit_4,
  input  wire  [3:0]  in_digit_5,
  input  wire  [3:0]  in_digit_6,
  input  wire  [3:0]  in_digit_7,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_seg_kind,
  output logic [6:0]  out_pattern,
  output logic [2:0]  out_pattern_len,
  output logic [7:0]  out_quiet_len,
  output logic        out_check_error,
  output logic        out_bad_digit,
  output logic        out_last
);
  import ean8_pkg::*;

  logic [QUIET_W-1:0] quiet_width_r;
  digits_t            digits;
  fifo_stat_t         fifo_stat;
  item_t              push_item;
  item_t              head;
  logic               push;
  logic               pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_width_r <= QUIET_RESET;
    end else if (cfg_wr_en) begin
      quiet_width_r <= cfg_wr_data;
    end
  end

  assign digits = {in_digit_7, in_digit_6, in_digit_5, in_digit_4,
                   in_digit_3, in_digit_2, in_digit_1, in_digit_0};

  ean8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_digits (digits),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_item (push_item)
  );

  ean8_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  ean8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .quiet_width     (quiet_width_r),
    .head            (head),
    .fifo_stat       (fifo_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_seg_kind    (out_seg_kind),
    .out_pattern     (out_pattern),
    .out_pattern_len (out_pattern_len),
    .out_quiet_len   (out_quiet_len),
    .out_check_error (out_check_error),
    .out_bad_digit   (out_bad_digit),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ean8_pkg::*;

  localparam int CODES_PER_PHASE = 65;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AT_CODE    = 100;

  // left-hand odd-parity symbols; the right-hand set is their complement
  localparam logic [6:0] LCODE [10] = '{7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
                                        7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};

  // first digit in the top nibble; the check digit gets filled in
  localparam logic [31:0] FIXED_CODES [10] = '{
    32'h0000_0000, 32'h9999_9990, 32'h1234_5670, 32'hA000_0000, 32'h0B00_0000,
    32'h00C0_0000, 32'h000D_0000, 32'h0000_E000, 32'h0000_0F00, 32'h0000_00A0};
  // taken as they stand, check digit included
  localparam logic [31:0] RAW_CODES [8] = '{
    32'h0123_4567, 32'h4567_8901, 32'h8901_2345, 32'h6789_6789,
    32'hFFFF_FFFF, 32'h1234_567A, 32'h1234_567F, 32'h1234_5671};

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] pat;
    logic [2:0] len;
    logic [7:0] qlen;
    logic       cerr;
    logic       bad;
    logic       fin;
  } seg_t;

  class seg_scoreboard;
    seg_t       want_q[$];
    logic [7:0] quiet_w;
    int         codes_in;
    int         beats_out;
    int         mismatches;

    function new();
      quiet_w    = QUIET_RESET;
      codes_in   = 0;
      beats_out  = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // weight 3 on even positions, raw nibble values go into the sum
    function logic [3:0] check_digit(input digits_t d);
      int sum;
      sum = 0;
      for (int i = 0; i < 7; i++)
        sum += (i % 2 == 0) ? 3 * int'(d[i]) : int'(d[i]);
      return 4'((10 - sum % 10) % 10);
    endfunction

    function void add_seg(input logic [1:0] kind, input logic [6:0] pat,
                          input logic [2:0] len, input logic [7:0] qlen,
                          input logic cerr, input logic bad, input logic fin);
      seg_t s;
      s = '{kind, pat, len, qlen, cerr, bad, fin};
      want_q.push_back(s);
    endfunction

    function void note_code(input digits_t d);
      logic cerr;
      cerr = (check_digit(d) != d[7]);
      codes_in++;
      add_seg(KIND_QUIET, '0, '0, quiet_w, cerr, 1'b0, 1'b0);
      add_seg(KIND_GUARD, PAT_SIDE_GUARD, LEN_SIDE_GUARD, '0, cerr, 1'b0, 1'b0);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (i == 4)
          add_seg(KIND_GUARD, PAT_CENTRE_GUARD, LEN_CENTRE_GUARD, '0, cerr, 1'b0, 1'b0);
        if (d[i] > MAX_DIGIT)
          add_seg(KIND_DIGIT, '0, '0, '0, cerr, 1'b1, 1'b0);
        else
          add_seg(KIND_DIGIT, (i < 4) ? LCODE[d[i]] : ~LCODE[d[i]], LEN_DIGIT, '0,
                  cerr, 1'b0, 1'b0);
      end
      add_seg(KIND_GUARD, PAT_SIDE_GUARD, LEN_SIDE_GUARD, '0, cerr, 1'b0, 1'b0);
      add_seg(KIND_QUIET, '0, '0, quiet_w, cerr, 1'b0, 1'b1);
    endfunction

    function void check_segment(input seg_t got);
      seg_t want;
      beats_out++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat %0d: kind %0d pat %h len %0d quiet %0d cerr %b bad %b last %b",
                   beats_out, got.kind, got.pat, got.len, got.qlen, got.cerr, got.bad, got.fin);
        return;
      end
      want = want_q.pop_front();
      if (got.kind !== want.kind || got.pat !== want.pat || got.len !== want.len ||
          got.qlen !== want.qlen || got.cerr !== want.cerr || got.bad !== want.bad ||
          got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat %0d (code %0d) mismatch:", beats_out, (beats_out - 1) / 13);
          $display("  want kind %0d pat %h len %0d quiet %0d cerr %b bad %b last %b",
                   want.kind, want.pat, want.len, want.qlen, want.cerr, want.bad, want.fin);
          $display("  got  kind %0d pat %h len %0d quiet %0d cerr %b bad %b last %b",
                   got.kind, got.pat, got.len, got.qlen, got.cerr, got.bad, got.fin);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] in_digit_0, in_digit_1, in_digit_2, in_digit_3;
  logic [3:0] in_digit_4, in_digit_5, in_digit_6, in_digit_7;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_seg_kind;
  logic [6:0] out_pattern;
  logic [2:0] out_pattern_len;
  logic [7:0] out_quiet_len;
  logic       out_check_error;
  logic       out_bad_digit;
  logic       out_last;

  seg_scoreboard sb;
  bit            calm;

  ean8_barcode_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_digit_0      (in_digit_0),
    .in_digit_1      (in_digit_1),
    .in_digit_2      (in_digit_2),
    .in_digit_3      (in_digit_3),
    .in_digit_4      (in_digit_4),
    .in_digit_5      (in_digit_5),
    .in_digit_6      (in_digit_6),
    .in_digit_7      (in_digit_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_seg_kind    (out_seg_kind),
    .out_pattern     (out_pattern),
    .out_pattern_len (out_pattern_len),
    .out_quiet_len   (out_quiet_len),
    .out_check_error (out_check_error),
    .out_bad_digit   (out_bad_digit),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  function automatic digits_t from_hex(input logic [31:0] v);
    digits_t d;
    for (int i = 0; i < NUM_DIGITS; i++)
      d[i] = v[31 - 4 * i -: 4];
    return d;
  endfunction

  task automatic drive_digits(input digits_t d);
    in_digit_0 <= d[0];
    in_digit_1 <= d[1];
    in_digit_2 <= d[2];
    in_digit_3 <= d[3];
    in_digit_4 <= d[4];
    in_digit_5 <= d[5];
    in_digit_6 <= d[6];
    in_digit_7 <= d[7];
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  // and leaves in_valid high so back-to-back codes need no extra assignment
  task automatic push_code(input digits_t d);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      drive_digits(digits_t'($urandom));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    drive_digits(d);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_code(d);
    @(negedge clk);
  endtask

  // quiet width may only change with the pipeline empty
  task automatic set_quiet(input logic [7:0] w);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    sb.quiet_w = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && sb.codes_in >= HOLD_AT_CODE) begin
        held      = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_segment({out_seg_kind, out_pattern, out_pattern_len, out_quiet_len,
                        out_check_error, out_bad_digit, out_last});
  end

  initial begin
    digits_t    d;
    logic [7:0] widths [6];
    sb          = new();
    calm        = 1'b0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    {in_digit_7, in_digit_6, in_digit_5, in_digit_4,
     in_digit_3, in_digit_2, in_digit_1, in_digit_0} = '0;
    widths = '{8'd0, 8'd255, 8'($urandom_range(2, 254)), 8'($urandom_range(2, 254)),
               8'd1, 8'($urandom_range(0, 255))};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed codes run at the reset quiet width
    foreach (FIXED_CODES[i]) begin
      d    = from_hex(FIXED_CODES[i]);
      d[7] = sb.check_digit(d);
      push_code(d);
    end
    foreach (RAW_CODES[i])
      push_code(from_hex(RAW_CODES[i]));

    for (int p = 0; p < 6; p++) begin
      set_quiet(widths[p]);
      calm = (p == 3);
      repeat (CODES_PER_PHASE) begin
        for (int i = 0; i < NUM_DIGITS; i++)
          d[i] = 4'($urandom_range(0, 9));
        case ($urandom_range(0, 99)) inside
          [0:64]:  d[7] = sb.check_digit(d);
          [65:79]: d[7] = 4'($urandom_range(0, 15));
          default: d    = digits_t'($urandom);
        endcase
        push_code(d);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d beats still expected", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
